// ===== hdl/sign_magnitude_alu_assert.svh =====
// Assertion macros for the sign-magnitude ALU checker.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef SIGN_MAGNITUDE_ALU_ASSERT_SVH
`define SIGN_MAGNITUDE_ALU_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SMA_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SMA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/sma_pkg.sv =====
// Shared types and constants for the sign-magnitude ALU.
// No dependencies.
`timescale 1ns / 1ps

package sma_pkg;

    localparam int WORD_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_EQ  = 3'd3,
        OP_GT  = 3'd4
    } op_t;

    // Flags from the operand stage
    typedef struct packed {
        op_t  op;
        logic sa;
        logic sb;
        logic za;
        logic zb;
        logic mag_ge;
        logic mag_eq;
    } s1_ctrl_t;

    // Flags from the arithmetic stage
    typedef struct packed {
        op_t  op;
        logic sum_sign;
        logic mul_sign;
        logic cmp_bit;
    } s2_ctrl_t;

endpackage

// ===== hdl/sma_front.sv =====
// Stage 1: splits operands into sign and magnitude, compares magnitudes.
// Depends on sma_pkg.
`timescale 1ns / 1ps

module sma_front #(
    parameter int WORD_WIDTH = sma_pkg::WORD_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  enable,
    input  logic                  valid_in,
    input  logic [2:0]            operation,
    input  logic [WORD_WIDTH-1:0] a,
    input  logic [WORD_WIDTH-1:0] b,
    output logic                  valid_out,
    output sma_pkg::s1_ctrl_t     ctrl_out,
    output logic [WORD_WIDTH-2:0] ma_out,
    output logic [WORD_WIDTH-2:0] mb_out
);

    localparam int MW = WORD_WIDTH - 1;

    logic              valid_reg;
    sma_pkg::s1_ctrl_t ctrl_reg, ctrl_next;
    logic [MW-1:0]     ma_reg, mb_reg;
    logic [MW-1:0]     ma, mb;

    assign ma = a[MW-1:0];
    assign mb = b[MW-1:0];

    always_comb
    begin
        ctrl_next.op     = sma_pkg::op_t'(operation);
        ctrl_next.sa     = a[MW];
        ctrl_next.sb     = b[MW];
        ctrl_next.za     = (ma == '0);
        ctrl_next.zb     = (mb == '0);
        ctrl_next.mag_ge = (ma >= mb);
        ctrl_next.mag_eq = (ma == mb);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable && valid_in)
        begin
            ctrl_reg <= ctrl_next;
            ma_reg   <= ma;
            mb_reg   <= mb;
        end
    end

    assign valid_out = valid_reg;
    assign ctrl_out  = ctrl_reg;
    assign ma_out    = ma_reg;
    assign mb_out    = mb_reg;

endmodule

// ===== hdl/sma_arith.sv =====
// Stage 2: magnitude add/subtract, compare decisions, partial products.
// Depends on sma_pkg.
`timescale 1ns / 1ps

module sma_arith #(
    parameter int WORD_WIDTH = sma_pkg::WORD_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  enable,
    input  logic                  valid_in,
    input  sma_pkg::s1_ctrl_t     ctrl_in,
    input  logic [WORD_WIDTH-2:0] ma,
    input  logic [WORD_WIDTH-2:0] mb,
    output logic                  valid_out,
    output sma_pkg::s2_ctrl_t     ctrl_out,
    output logic [WORD_WIDTH-2:0] sum_out,
    output logic [WORD_WIDTH-2:0] p0_out,
    output logic [WORD_WIDTH-2-(WORD_WIDTH/2):0] p1_out,
    output logic [WORD_WIDTH-2-(WORD_WIDTH/2):0] p2_out
);

    localparam int MW = WORD_WIDTH - 1;
    localparam int H  = (MW + 1) / 2;   // low half width
    localparam int L  = MW - H;         // high half width

    logic              valid_reg;
    sma_pkg::s2_ctrl_t ctrl_reg, ctrl_next;
    logic [MW-1:0]     sum_reg, sum_next;
    logic [MW-1:0]     p0_reg;
    logic [L-1:0]      p1_reg, p2_reg;

    logic              sb_eff;
    logic [MW:0]       add_full;
    logic              na, nb;
    logic [2*H-1:0]    p0_full;
    logic [H+L-1:0]    p1_full, p2_full;

    assign sb_eff   = ctrl_in.sb ^ (ctrl_in.op == sma_pkg::OP_SUB);
    assign add_full = {1'b0, ma} + {1'b0, mb};

    // Only the cross terms' low bits reach the kept product; high*high drops out.
    assign p0_full = {{H{1'b0}}, ma[H-1:0]} * {{H{1'b0}}, mb[H-1:0]};
    assign p1_full = {{L{1'b0}}, ma[H-1:0]} * {{H{1'b0}}, mb[MW-1:H]};
    assign p2_full = {{H{1'b0}}, ma[MW-1:H]} * {{L{1'b0}}, mb[H-1:0]};

    // negative zero counts as zero
    assign na = ctrl_in.sa && !ctrl_in.za;
    assign nb = ctrl_in.sb && !ctrl_in.zb;

    always_comb
    begin
        ctrl_next.op       = ctrl_in.op;
        ctrl_next.mul_sign = ctrl_in.sa ^ ctrl_in.sb;
        if (ctrl_in.sa == sb_eff)
        begin
            sum_next           = add_full[MW-1:0];
            ctrl_next.sum_sign = ctrl_in.sa;
        end
        else if (ctrl_in.mag_ge)
        begin
            sum_next           = ma - mb;
            ctrl_next.sum_sign = ctrl_in.sa;
        end
        else
        begin
            sum_next           = mb - ma;
            ctrl_next.sum_sign = sb_eff;
        end

        if (ctrl_in.op == sma_pkg::OP_EQ)
        begin
            ctrl_next.cmp_bit = (ctrl_in.za && ctrl_in.zb)
                             || (ctrl_in.sa == ctrl_in.sb && ctrl_in.mag_eq);
        end
        else if (na != nb)
        begin
            ctrl_next.cmp_bit = !na;
        end
        else if (na)
        begin
            ctrl_next.cmp_bit = !ctrl_in.mag_ge;
        end
        else
        begin
            ctrl_next.cmp_bit = ctrl_in.mag_ge && !ctrl_in.mag_eq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable && valid_in)
        begin
            ctrl_reg <= ctrl_next;
            sum_reg  <= sum_next;
            p0_reg   <= p0_full[MW-1:0];
            p1_reg   <= p1_full[L-1:0];
            p2_reg   <= p2_full[L-1:0];
        end
    end

    assign valid_out = valid_reg;
    assign ctrl_out  = ctrl_reg;
    assign sum_out   = sum_reg;
    assign p0_out    = p0_reg;
    assign p1_out    = p1_reg;
    assign p2_out    = p2_reg;

endmodule

// ===== hdl/sma_pack.sv =====
// Stage 3: finishes the product, picks the result and packs it into the output register.
// Depends on sma_pkg.
`timescale 1ns / 1ps

module sma_pack #(
    parameter int WORD_WIDTH = sma_pkg::WORD_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  enable,
    input  logic                  valid_in,
    input  sma_pkg::s2_ctrl_t     ctrl_in,
    input  logic [WORD_WIDTH-2:0] sum_in,
    input  logic [WORD_WIDTH-2:0] p0_in,
    input  logic [WORD_WIDTH-2-(WORD_WIDTH/2):0] p1_in,
    input  logic [WORD_WIDTH-2-(WORD_WIDTH/2):0] p2_in,
    output logic                  valid_out,
    output logic [WORD_WIDTH-1:0] result_out
);

    localparam int MW = WORD_WIDTH - 1;
    localparam int H  = (MW + 1) / 2;
    localparam int L  = MW - H;

    logic                  valid_reg;
    logic [WORD_WIDTH-1:0] result_reg, result_next;
    logic [L:0]            cross_full;
    logic [MW:0]           prod_full;
    logic [MW-1:0]         mag;
    logic                  sign;

    assign cross_full = {1'b0, p1_in} + {1'b0, p2_in};
    assign prod_full  = {1'b0, p0_in} + {1'b0, cross_full[L-1:0], {H{1'b0}}};

    always_comb
    begin
        mag         = sum_in;
        sign        = ctrl_in.sum_sign;
        result_next = '0;
        unique case (ctrl_in.op) inside
            sma_pkg::OP_ADD, sma_pkg::OP_SUB:
            begin
                mag  = sum_in;
                sign = ctrl_in.sum_sign;
                result_next = {sign && (mag != '0), mag};
            end
            sma_pkg::OP_MUL:
            begin
                mag  = prod_full[MW-1:0];
                sign = ctrl_in.mul_sign;
                result_next = {sign && (mag != '0), mag};
            end
            sma_pkg::OP_EQ, sma_pkg::OP_GT:
            begin
                result_next = {{MW{1'b0}}, ctrl_in.cmp_bit};
            end
            default:
            begin
                result_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enable && valid_in)
        begin
            result_reg <= result_next;
        end
    end

    assign valid_out  = valid_reg;
    assign result_out = result_reg;

endmodule

// ===== hdl/sign_magnitude_alu.sv =====
// Sign-magnitude ALU: add, subtract, multiply, equal, greater than.
// Each accepted input word passes through the front, arith and pack stage registers before it is the output word.
// Throughput: one word per cycle while the output is not stalled; the 3-stage pipeline is set by the split multiply.
// Each stage holds only while the stage after it is full and blocked.
// Reset (rst_n low, asynchronous) clears all stage valid bits; data regs are not reset.
`timescale 1ns / 1ps

module sign_magnitude_alu #(
    parameter int WORD_WIDTH = sma_pkg::WORD_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [2:0]            operation,
    input  logic [WORD_WIDTH-1:0] a,
    input  logic [WORD_WIDTH-1:0] b,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [WORD_WIDTH-1:0] result
);

    localparam int MW = WORD_WIDTH - 1;
    localparam int L  = MW - (MW + 1) / 2;

    logic              v1, v2, v3;
    logic              en1, en2, en3;
    sma_pkg::s1_ctrl_t ctrl1;
    sma_pkg::s2_ctrl_t ctrl2;
    logic [MW-1:0]     ma1, mb1;
    logic [MW-1:0]     sum2, p0_2;
    logic [L-1:0]      p1_2, p2_2;

    // a stage loads when empty or when its word moves on
    assign en3      = !v3 || !out_stall;
    assign en2      = !v2 || en3;
    assign en1      = !v1 || en2;
    assign in_stall = !en1;

    sma_front #(.WORD_WIDTH(WORD_WIDTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (en1),
        .valid_in  (in_valid),
        .operation (operation),
        .a         (a),
        .b         (b),
        .valid_out (v1),
        .ctrl_out  (ctrl1),
        .ma_out    (ma1),
        .mb_out    (mb1)
    );

    sma_arith #(.WORD_WIDTH(WORD_WIDTH)) u_arith (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (en2),
        .valid_in  (v1),
        .ctrl_in   (ctrl1),
        .ma        (ma1),
        .mb        (mb1),
        .valid_out (v2),
        .ctrl_out  (ctrl2),
        .sum_out   (sum2),
        .p0_out    (p0_2),
        .p1_out    (p1_2),
        .p2_out    (p2_2)
    );

    sma_pack #(.WORD_WIDTH(WORD_WIDTH)) u_pack (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (en3),
        .valid_in   (v2),
        .ctrl_in    (ctrl2),
        .sum_in     (sum2),
        .p0_in      (p0_2),
        .p1_in      (p1_2),
        .p2_in      (p2_2),
        .valid_out  (v3),
        .result_out (result)
    );

    assign out_valid = v3;

endmodule

// ===== hdl/sma_checker.sv =====
// Port-level checks for the sign-magnitude ALU, bound to the top level.
// Depends on sma_pkg, sign_magnitude_alu_assert.svh and sign_magnitude_alu.
`timescale 1ns / 1ps
`include "sign_magnitude_alu_assert.svh"

module sma_checker #(
    parameter int WORD_WIDTH = sma_pkg::WORD_WIDTH_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [WORD_WIDTH-1:0] result
);

    logic out_held;
    logic neg_out;

    assign out_held = out_valid && out_stall;
    assign neg_out  = out_valid && result[WORD_WIDTH-1];

    // a stalled output word holds
    `SMA_ASSERT_NEXT(a_out_hold, out_held, out_valid && $stable(result), "stalled word changed")

    // input backs up only when every stage is full and the output is blocked
    `SMA_ASSERT_IMPL(a_stall_full, in_stall, out_held, "input stalled with room in pipeline")

    // zero always comes out as positive zero
    `SMA_ASSERT_IMPL(a_no_neg_zero, neg_out, |result[WORD_WIDTH-2:0], "negative zero on output")

endmodule

bind sign_magnitude_alu sma_checker #(.WORD_WIDTH(WORD_WIDTH)) u_sma_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .result    (result)
);
